### rtl/core/sr90_pkg.sv
// Shared types and constants for the slice rotation block.
package sr90_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SW_W       = 10;
  localparam int SH_W       = 8;
  localparam int PIX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_DIR   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  localparam logic [SW_W-1:0] SLICE_WIDTH_RST  = 10'd512;
  localparam logic [SH_W-1:0] SLICE_HEIGHT_RST = 8'd128;

  typedef enum logic [1:0] {
    ST_EFF,
    ST_BASE,
    ST_LAST,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic calc_eff;
    logic calc_base;
    logic restart;
    logic do_load;
    logic do_fetch;
  } ctrl_t;

  typedef struct packed {
    logic cfg_hit;
    logic room;
  } status_t;

endpackage

### rtl/core/sr90_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sr90_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/sr90_ctrl.sv
// Controller state machine: geometry setup after reset or configuration, then item handling.
module sr90_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  sr90_pkg::status_t status,
  output sr90_pkg::ctrl_t   ctrl
);

  sr90_pkg::state_t state;
  sr90_pkg::state_t state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sr90_pkg::ST_EFF;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sr90_pkg::ST_EFF:  state_next = sr90_pkg::ST_BASE;
      sr90_pkg::ST_BASE: state_next = sr90_pkg::ST_LAST;
      sr90_pkg::ST_LAST: state_next = sr90_pkg::ST_RUN;
      sr90_pkg::ST_RUN:  state_next = sr90_pkg::ST_RUN;
      default:           state_next = sr90_pkg::ST_EFF;
    endcase
    if (status.cfg_hit) begin
      state_next = sr90_pkg::ST_EFF;
    end
  end

  assign accept = s_tvalid && s_tready;

  always_comb begin
    s_tready      = 1'b0;
    ctrl.calc_eff  = 1'b0;
    ctrl.calc_base = 1'b0;
    ctrl.restart   = 1'b0;
    case (state)
      sr90_pkg::ST_EFF:  ctrl.calc_eff = 1'b1;
      sr90_pkg::ST_BASE: ctrl.calc_base = 1'b1;
      sr90_pkg::ST_LAST: ctrl.restart = 1'b1;
      sr90_pkg::ST_RUN:  s_tready = status.room;
      default:           s_tready = 1'b0;
    endcase
    ctrl.do_load  = accept && (s_tuser == sr90_pkg::OP_LOAD);
    ctrl.do_fetch = accept && (s_tuser == sr90_pkg::OP_FETCH);
  end

endmodule

### rtl/core/sr90_datapath.sv
// Datapath: configuration registers, address counters, slice store and output queue.
module sr90_datapath #(
  parameter int MAX_WIDTH  = 512,
  parameter int SLICE_ROWS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sr90_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sr90_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sr90_pkg::PIX_W-1:0]        s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sr90_pkg::PIX_W-1:0]        m_tdata,
  output logic                              m_tlast,
  input  sr90_pkg::ctrl_t                   ctrl,
  output sr90_pkg::status_t                 status
);

  localparam int DEPTH = MAX_WIDTH * SLICE_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (SLICE_ROWS > 1) ? $clog2(SLICE_ROWS) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = RW + WW;

  logic [sr90_pkg::SW_W-1:0] slice_width;
  logic [sr90_pkg::SH_W-1:0] slice_height;
  logic                      rotate_dir;

  logic [WW-1:0] weff;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [AW-1:0] base;
  logic [AW-1:0] last_addr;
  logic [PW-1:0] base_prod;
  logic [AW-1:0] w_a;

  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] widx;
  logic          last_now;

  logic [sr90_pkg::PIX_W-1:0] rdata;
  logic                       pend;
  logic                       pend_last;

  logic [sr90_pkg::PIX_W-1:0] q0_pix;
  logic [sr90_pkg::PIX_W-1:0] q1_pix;
  logic                       q0_last;
  logic                       q1_last;
  logic                       v0;
  logic                       v1;
  logic                       pop;
  logic [1:0]                 occ;

  assign status.cfg_hit = cfg_we && (cfg_index == sr90_pkg::REG_SLICE_WIDTH ||
                                     cfg_index == sr90_pkg::REG_SLICE_HEIGHT ||
                                     cfg_index == sr90_pkg::REG_ROTATE_DIR);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width  <= sr90_pkg::SLICE_WIDTH_RST;
      slice_height <= sr90_pkg::SLICE_HEIGHT_RST;
      rotate_dir   <= sr90_pkg::DIR_CW;
    end else if (cfg_we) begin
      case (cfg_index)
        sr90_pkg::REG_SLICE_WIDTH:  slice_width <= cfg_data;
        sr90_pkg::REG_SLICE_HEIGHT: slice_height <= cfg_data[sr90_pkg::SH_W-1:0];
        sr90_pkg::REG_ROTATE_DIR:   rotate_dir <= cfg_data[0];
        default:                    ;
      endcase
    end
  end

  assign base_prod = PW'(hm1) * PW'(weff);
  assign w_a       = AW'(weff);

  always_ff @(posedge clk) begin
    if (ctrl.calc_eff) begin
      if (slice_width == '0) begin
        weff <= WW'(1);
        wm1  <= '0;
      end else if (32'(slice_width) > MAX_WIDTH) begin
        weff <= WW'(MAX_WIDTH);
        wm1  <= CW'(MAX_WIDTH - 1);
      end else begin
        weff <= WW'(slice_width);
        wm1  <= CW'(slice_width - 10'd1);
      end
      if (slice_height == '0) begin
        hm1  <= '0;
      end else if (32'(slice_height) > SLICE_ROWS) begin
        hm1  <= RW'(SLICE_ROWS - 1);
      end else begin
        hm1  <= RW'(slice_height - 8'd1);
      end
    end
    if (ctrl.calc_base) begin
      base <= AW'(base_prod);
    end
  end

  always_comb begin
    if (rotate_dir == sr90_pkg::DIR_CW) begin
      last_now = (rd_col == wm1) && (rd_row == '0);
    end else begin
      last_now = (rd_col == '0) && (rd_row == hm1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.restart) begin
      last_addr <= base + AW'(wm1);
      widx      <= '0;
      if (rotate_dir == sr90_pkg::DIR_CW) begin
        rd_col  <= '0;
        rd_row  <= hm1;
        rd_addr <= base;
      end else begin
        rd_col  <= wm1;
        rd_row  <= '0;
        rd_addr <= AW'(wm1);
      end
    end else begin
      if (ctrl.do_load) begin
        widx <= (widx == last_addr) ? '0 : widx + AW'(1);
      end
      if (ctrl.do_fetch) begin
        if (rotate_dir == sr90_pkg::DIR_CW) begin
          if (rd_row == '0) begin
            rd_row <= hm1;
            if (rd_col == wm1) begin
              rd_col  <= '0;
              rd_addr <= base;
            end else begin
              rd_col  <= rd_col + CW'(1);
              rd_addr <= rd_addr + base + AW'(1);
            end
          end else begin
            rd_row  <= rd_row - RW'(1);
            rd_addr <= rd_addr - w_a;
          end
        end else begin
          if (rd_row == hm1) begin
            rd_row <= '0;
            if (rd_col == '0) begin
              rd_col  <= wm1;
              rd_addr <= AW'(wm1);
            end else begin
              rd_col  <= rd_col - CW'(1);
              rd_addr <= rd_addr - base - AW'(1);
            end
          end else begin
            rd_row  <= rd_row + RW'(1);
            rd_addr <= rd_addr + w_a;
          end
        end
      end
    end
  end

  sr90_ram #(
    .WIDTH (sr90_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctrl.do_load),
    .waddr (widx),
    .wdata (s_tdata),
    .re    (ctrl.do_fetch),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctrl.do_fetch;
    end
    if (ctrl.do_fetch) begin
      pend_last <= last_now;
    end
  end

  assign pop = v0 && m_tready;
  assign occ = 2'(v0) + 2'(v1) + 2'(pend) - 2'(pop);
  assign status.room = (occ < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        q0_pix  <= q1_pix;
        q0_last <= q1_last;
        v1      <= pend;
        if (pend) begin
          q1_pix  <= rdata;
          q1_last <= pend_last;
        end
      end else begin
        v0 <= pend;
        if (pend) begin
          q0_pix  <= rdata;
          q0_last <= pend_last;
        end
      end
    end else if (pend) begin
      if (!v0) begin
        v0      <= 1'b1;
        q0_pix  <= rdata;
        q0_last <= pend_last;
      end else begin
        v1      <= 1'b1;
        q1_pix  <= rdata;
        q1_last <= pend_last;
      end
    end
  end

  assign m_tvalid = v0;
  assign m_tdata  = q0_pix;
  assign m_tlast  = q0_last;

endmodule

### rtl/core/slice_rotate_90_top.sv
// Top level of the slice rotation block: controller and datapath.
// Fetches pass the store's read register and output queue; loads give no result. Throughput
// is one item per cycle while the queue has room, limited by the single read port of the
// slice store and a two-entry output queue that keeps items flowing while a result waits.
// After reset or a configuration write geometry is set up in ST_EFF, ST_BASE and ST_LAST
// with s_tready low; configuration resets to 512 by 128 clockwise, store contents undefined.
module slice_rotate_90_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int SLICE_ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sr90_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sr90_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sr90_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
  input  logic                            s_tuser,   // opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sr90_pkg::PIX_W-1:0]      m_tdata,   // pixel_out
  output logic                            m_tlast
);

  sr90_pkg::ctrl_t   ctrl;
  sr90_pkg::status_t status;

  sr90_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  sr90_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SLICE_ROWS (SLICE_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .ctrl      (ctrl),
    .status    (status)
  );

endmodule

### bench/slice_rotate_90_top_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the 90 degree slice rotation block.
module slice_rotate_90_top_test;
  import sr90_pkg::*;

  localparam int MAX_W        = 512;
  localparam int MAX_H        = 128;
  localparam int STORE_DEPTH  = MAX_W * MAX_H;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fin;
  } rot_pix_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  s_tuser   = OP_LOAD;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;

  slice_rotate_90_top #(
    .MAX_WIDTH (MAX_W),
    .SLICE_ROWS(MAX_H)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the slice store, geometry and read position.
  logic [PIX_W-1:0] slice_mem [STORE_DEPTH];
  int unsigned      wr_idx;
  int unsigned      written_hi = 0;
  int unsigned      rd_col;
  int unsigned      rd_row;
  logic [SW_W-1:0]  sl_width;
  logic [SH_W-1:0]  sl_height;
  logic             sl_dir;

  pix_item_t pix_pending [$];
  rot_pix_t  rotated_due [$];

  bit no_idle = 1'b0;
  int n_errors  = 0;
  int n_loads   = 0;
  int n_fetches = 0;
  int n_checked = 0;
  int n_phases  = 0;

  function automatic int unsigned eff_width();
    if (sl_width == 0) return 1;
    if (sl_width > MAX_W) return MAX_W;
    return sl_width;
  endfunction

  function automatic int unsigned eff_height();
    if (sl_height == 0) return 1;
    if (sl_height > MAX_H) return MAX_H;
    return sl_height;
  endfunction

  function automatic void restart_read();
    if (sl_dir == DIR_CW) begin
      rd_col = 0;
      rd_row = eff_height() - 1;
    end else begin
      rd_col = eff_width() - 1;
      rd_row = 0;
    end
  endfunction

  function automatic void rotate_step(input pix_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    rot_pix_t    res;
    w = eff_width();
    h = eff_height();
    if (it.op == OP_LOAD) begin
      if (wr_idx >= w * h) wr_idx = 0;
      slice_mem[wr_idx] = it.pix;
      if (wr_idx >= written_hi) written_hi = wr_idx + 1;
      wr_idx++;
      if (wr_idx >= w * h) wr_idx = 0;
      n_loads++;
    end else begin
      if (rd_col >= w || rd_row >= h) restart_read();
      addr = rd_row * w + rd_col;
      res.pix = slice_mem[addr];
      if (sl_dir == DIR_CW) begin
        res.fin = (rd_col == w - 1) && (rd_row == 0);
        if (rd_row == 0) begin
          rd_row = h - 1;
          rd_col = (rd_col == w - 1) ? 0 : rd_col + 1;
        end else begin
          rd_row--;
        end
      end else begin
        res.fin = (rd_col == 0) && (rd_row == h - 1);
        if (rd_row == h - 1) begin
          rd_row = 0;
          rd_col = (rd_col == 0) ? w - 1 : rd_col - 1;
        end else begin
          rd_row++;
        end
      end
      rotated_due.push_back(res);
      n_fetches++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void push_item(input logic op, input logic [PIX_W-1:0] pix);
    pix_item_t it;
    it.op  = op;
    it.pix = pix;
    pix_pending.push_back(it);
  endfunction

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_SLICE_WIDTH) sl_width = val[SW_W-1:0];
    else if (idx == REG_SLICE_HEIGHT) sl_height = val[SH_W-1:0];
    else if (idx == REG_ROTATE_DIR) sl_dir = val[0];
    else return;
    wr_idx = 0;
    restart_read();
  endtask

  task automatic reg_write_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pix_pending.size() != 0 || s_tvalid || rotated_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  pix_item_t   cur_item;
  int unsigned tx_gap;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) rotate_step(cur_item);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pix_pending.size() > 0) begin
          cur_item = pix_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.pix;
          s_tuser  <= cur_item.op;
          tx_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  int unsigned rx_stall;

  always @(posedge clk) begin
    rot_pix_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rotated_due.size() == 0) begin
          $error("unexpected item: pixel_out %0d last %0d", m_tdata, m_tlast);
          n_errors++;
        end else begin
          want = rotated_due.pop_front();
          n_checked++;
          if (m_tdata !== want.pix) begin
            $error("pixel_out mismatch: expected %0d, got %0d", want.pix, m_tdata);
            n_errors++;
          end
          if (m_tlast !== want.fin) begin
            $error("last mismatch: expected %0d, got %0d", want.fin, m_tlast);
            n_errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[slice_rotate_90_top] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned           mix_total;
    int unsigned           mix_len;
    int unsigned           fill_len;
    int unsigned           fetch_pct;
    int                    p;
    logic [CFG_DATA_W-1:0] wdat;
    logic [CFG_DATA_W-1:0] hdat;
    logic [CFG_DATA_W-1:0] ddat;
    logic                  dir;

    sl_width  = SLICE_WIDTH_RST;
    sl_height = SLICE_HEIGHT_RST;
    sl_dir    = DIR_CW;
    wr_idx    = 0;
    restart_read();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A 3 by 2 slice read in both directions, with a write wrap in between.
    reg_write(REG_SLICE_WIDTH, 10'd3);
    reg_write(REG_SLICE_HEIGHT, 10'd2);
    reg_write(REG_ROTATE_DIR, CFG_DATA_W'(DIR_CW));
    reg_write_done();
    push_item(OP_LOAD, 8'h00);
    push_item(OP_LOAD, 8'hFF);
    push_item(OP_LOAD, 8'h55);
    push_item(OP_LOAD, 8'hAA);
    push_item(OP_LOAD, 8'h01);
    push_item(OP_LOAD, 8'h80);
    repeat (7) push_item(OP_FETCH, 8'h00);
    push_item(OP_LOAD, 8'h7E);
    push_item(OP_FETCH, 8'hFF);
    push_item(OP_FETCH, 8'h00);
    wait_drained();
    reg_write(REG_ROTATE_DIR, CFG_DATA_W'(DIR_CCW));
    reg_write_done();
    repeat (7) push_item(OP_FETCH, 8'h00);
    wait_drained();
    // A write to an unused index must leave the read position alone.
    reg_write(REG_UNUSED, 10'h3FF);
    reg_write_done();
    push_item(OP_FETCH, 8'h00);
    push_item(OP_FETCH, 8'h00);
    wait_drained();
    n_phases = 3;

    mix_total  = 0;
    p          = 0;
    while (p < 8 || mix_total < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(3) == 0);
      case (p)
        0: begin wdat = 10'd0;   hdat = 10'd0;   dir = DIR_CW;  end
        1: begin wdat = 10'h3FF; hdat = 10'd1;   dir = DIR_CCW; end
        2: begin wdat = 10'd512; hdat = 10'd1;   dir = DIR_CW;  end
        3: begin wdat = 10'd1;   hdat = 10'h3FF; dir = DIR_CW;  end
        4: begin wdat = 10'd1;   hdat = 10'd128; dir = DIR_CCW; end
        default: begin
          if (p % 4 == 0) begin
            wdat = CFG_DATA_W'($urandom_range(1, 40));
            hdat = CFG_DATA_W'($urandom_range(1, 12));
          end else begin
            wdat = CFG_DATA_W'($urandom_range(0, 8));
            hdat = CFG_DATA_W'($urandom_range(0, 8));
          end
          dir = 1'($urandom_range(1));
        end
      endcase
      ddat    = CFG_DATA_W'($urandom_range(1023));
      ddat[0] = dir;
      if (p >= 5 && $urandom_range(3) == 0) begin
        reg_write(REG_ROTATE_DIR, ddat);
      end else begin
        reg_write(REG_SLICE_WIDTH, wdat);
        reg_write(REG_SLICE_HEIGHT, hdat);
        reg_write(REG_ROTATE_DIR, ddat);
      end
      if ($urandom_range(7) == 0) reg_write(REG_UNUSED, CFG_DATA_W'($urandom));
      reg_write_done();
      // Loads always start at entry zero, so the slice is filled only when it reaches
      // past the entries written so far; no fetch can then read an unwritten entry.
      fill_len = 0;
      if (eff_width() * eff_height() > written_hi) begin
        fill_len = eff_width() * eff_height();
        repeat (fill_len) push_item(OP_LOAD, PIX_W'($urandom));
      end
      mix_len   = $urandom_range(8, 24);
      fetch_pct = $urandom_range(20, 90);
      repeat (mix_len) begin
        push_item(($urandom_range(99) < fetch_pct) ? OP_FETCH : OP_LOAD, PIX_W'($urandom));
      end
      mix_total += fill_len + mix_len;
      p++;
      wait_drained();
    end
    n_phases += p;

    repeat (8) @(posedge clk);
    $display("Ran %0d slice setups in both directions, including degenerate and saturated sizes.",
             n_phases);
    $display("Accepted %0d loads and %0d fetches; %0d rotated pixels checked, %0d errors.",
             n_loads, n_fetches, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[slice_rotate_90_top] OK");
    end else begin
      $display("[slice_rotate_90_top] ERROR");
    end
    $finish;
  end

endmodule

### slice_rotate_90_top.f
rtl/core/sr90_pkg.sv
rtl/core/sr90_ram.sv
rtl/core/sr90_ctrl.sv
rtl/core/sr90_datapath.sv
rtl/core/slice_rotate_90_top.sv
bench/slice_rotate_90_top_test.sv
